// ===== design/gac_pkg.sv =====
package gac_pkg;

    // Phase codes as seen on the result channel.
    localparam logic [1:0] PH_TURN_POS  = 2'd0;
    localparam logic [1:0] PH_MOVE      = 2'd1;
    localparam logic [1:0] PH_TURN_ORNT = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAX_LIN   = 3'd0;
    localparam logic [2:0] REG_MAX_ANG   = 3'd1;
    localparam logic [2:0] REG_BEAR_TOL  = 3'd2;
    localparam logic [2:0] REG_POS_TOL   = 3'd3;
    localparam logic [2:0] REG_HEAD_TOL  = 3'd4;
    localparam logic [2:0] REG_ROT_GAIN  = 3'd5;
    localparam logic [2:0] REG_TRAN_GAIN = 3'd6;

    // CORDIC angle word: Q.30 radians, sign plus headroom past pi.
    localparam int ZW = 34;
    // CORDIC vector word: the normalized magnitude sits at 2^40 and grows by
    // the CORDIC gain, so 45 bits plus sign are enough.
    localparam int VW = 46;
    localparam int TAB_LEN = 20;
    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Arc tangent of 2^-i in Q.30 radians.
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 34'sd843314857;
                5'd1: r = 34'sd497837829;
                5'd2: r = 34'sd263043837;
                5'd3: r = 34'sd133525159;
                5'd4: r = 34'sd67021687;
                5'd5: r = 34'sd33543516;
                5'd6: r = 34'sd16775851;
                5'd7: r = 34'sd8388437;
                5'd8: r = 34'sd4194283;
                5'd9: r = 34'sd2097149;
                5'd10: r = 34'sd1048576;
                5'd11: r = 34'sd524288;
                5'd12: r = 34'sd262144;
                5'd13: r = 34'sd131072;
                5'd14: r = 34'sd65536;
                5'd15: r = 34'sd32768;
                5'd16: r = 34'sd16384;
                5'd17: r = 34'sd8192;
                5'd18: r = 34'sd4096;
                5'd19: r = 34'sd2048;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;       // capture the input transaction
        logic sqrt_start; // begin distance root
        logic cordic_start;
        logic [1:0] cordic_sel; // 0 yaw, 1 bearing, 2 mirrored bearing
        logic decide;     // evaluate phase logic and load the result
    } gac_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
        logic need_mirror;
    } gac_stat_t;

    typedef struct packed {
        logic [14:0] max_lin;
        logic [14:0] max_ang;
        logic [13:0] bear_tol;
        logic [14:0] pos_tol;
        logic [13:0] head_tol;
        logic [15:0] rot_gain;
        logic [15:0] tran_gain;
    } gac_cfg_t;

endpackage

// ===== design/gac_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module gac_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] value,
    output logic        done,
    output logic [15:0] root
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // One restoring step of the classic digit-by-digit root.
    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = value;
            res_next  = '0;
            bit_next  = 32'h4000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= res_reg + bit_reg) begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[15:0];
endmodule

// ===== design/gac_cordic.sv =====
// Vectoring CORDIC for atan2: normalizes, then one micro-rotation a cycle.
module gac_cordic #(
    parameter int CORDIC_ITERS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [35:0] y_in,
    input  logic signed [35:0] x_in,
    output logic               done,
    output logic signed [gac_pkg::ZW-1:0] angle
);
    import gac_pkg::*;

    localparam int ITERS = (CORDIC_ITERS < TAB_LEN) ? CORDIC_ITERS : TAB_LEN;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_NORM = 4'b0010,
        C_ROT  = 4'b0100,
        C_FIN  = 4'b1000
    } cst_t;

    cst_t state_reg, state_next;
    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0] i_reg, i_next;
    logic zero_reg, zero_next;
    logic done_reg, done_next;
    logic signed [VW-1:0] ax, ay, dx, dy;

    always_comb begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        ax = x_reg[VW-1] ? -x_reg : x_reg;
        ay = y_reg[VW-1] ? -y_reg : y_reg;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    // Left half-plane folds over by pi.
                    zero_next = (x_in == '0) && (y_in == '0);
                    if (x_in < 0) begin
                        z_next = (y_in >= 0) ? PI_Q30 : -PI_Q30;
                        x_next = -VW'(x_in);
                        y_next = -VW'(y_in);
                    end else begin
                        z_next = '0;
                        x_next = VW'(x_in);
                        y_next = VW'(y_in);
                    end
                    i_next = '0;
                    state_next = C_NORM;
                end
            end
            C_NORM: begin
                // Double until the larger magnitude reaches 2^40.
                if (zero_reg || ax[VW-2:40] != '0 || ay[VW-2:40] != '0) begin
                    state_next = zero_reg ? C_FIN : C_ROT;
                end else begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
            end
            C_ROT: begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_entry(i_reg);
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_entry(i_reg);
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(ITERS - 1)) begin
                    state_next = C_FIN;
                end
            end
            C_FIN: begin
                if (zero_reg) begin
                    z_next = '0;
                end else if (z_reg > PI_Q30) begin
                    z_next = PI_Q30;
                end else if (z_reg < -PI_Q30) begin
                    z_next = -PI_Q30;
                end
                done_next = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign angle = z_reg;
endmodule

// ===== design/gac_datapath.sv =====
// Datapath: input capture, root and CORDIC units, phase decision, result.
module gac_datapath #(
    parameter int FRAC_BITS = 12,
    parameter int CORDIC_ITERS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gac_pkg::gac_cmd_t  cmd,
    output gac_pkg::gac_stat_t stat,
    input  gac_pkg::gac_cfg_t  cfg,
    input  logic               s_restart,
    input  logic signed [15:0] s_goal_rel_x,
    input  logic signed [15:0] s_goal_rel_y,
    input  logic signed [15:0] s_goal_quat_w,
    input  logic signed [15:0] s_goal_quat_x,
    input  logic signed [15:0] s_goal_quat_y,
    input  logic signed [15:0] s_goal_quat_z,
    output logic signed [15:0] m_linear_cmd,
    output logic signed [15:0] m_angular_cmd,
    output logic               m_cmd_valid,
    output logic [1:0]         m_phase_now,
    output logic               m_aligned
);
    import gac_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam int AW = 20;
    localparam logic signed [AW-1:0] NEAR_D = AW'(((1 << FRAC_BITS) + 50) / 100);

    logic restart_reg;
    logic signed [15:0] x_reg, y_reg;
    logic signed [35:0] yaw_num_reg, yaw_den_reg;
    logic [1:0] phase_reg, phase_next;
    logic [15:0] d_reg;
    logic signed [AW-1:0] yaw_reg, bear_reg;
    logic signed [AW-1:0] pi_f, half_pi_f;

    // Quaternion terms are products; register them once at capture.
    logic signed [31:0] pxx, pww, pzz, pyy, pxy, pwz;
    always_comb begin
        pxx = s_goal_quat_x * s_goal_quat_x;
        pww = s_goal_quat_w * s_goal_quat_w;
        pzz = s_goal_quat_z * s_goal_quat_z;
        pyy = s_goal_quat_y * s_goal_quat_y;
        pxy = s_goal_quat_x * s_goal_quat_y;
        pwz = s_goal_quat_w * s_goal_quat_z;
    end

    // Square of distance.
    logic [31:0] dsq;
    assign dsq = 32'(x_reg * x_reg) + 32'(y_reg * y_reg);

    logic sq_done;
    logic [15:0] sq_root;
    gac_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sqrt_start),
        .value(dsq), .done(sq_done), .root(sq_root)
    );

    logic signed [35:0] cy, cx;
    logic c_done;
    logic signed [ZW-1:0] c_angle;
    always_comb begin
        unique case (cmd.cordic_sel)
            2'd0: begin cy = yaw_num_reg; cx = yaw_den_reg; end
            2'd1: begin cy = 36'(y_reg); cx = 36'(x_reg); end
            default: begin cy = 36'(y_reg); cx = -36'(x_reg); end
        endcase
    end
    gac_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.cordic_start),
        .y_in(cy), .x_in(cx), .done(c_done), .angle(c_angle)
    );

    // Round Q.30 to Q.FRAC_BITS half up.
    function automatic logic signed [AW-1:0] to_frac(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        begin
            t = (z + (ZW'(1) <<< (SH - 1))) >>> SH;
            return AW'(t);
        end
    endfunction

    assign pi_f = to_frac(PI_Q30);
    assign half_pi_f = to_frac(HALF_PI_Q30);

    logic signed [AW-1:0] angle_f;
    assign angle_f = to_frac(c_angle);
    logic [1:0] sel_reg;
    logic signed [AW:0] diff, diff_w;
    always_comb begin
        diff = (AW+1)'(yaw_reg) - (AW+1)'(bear_reg);
        diff_w = diff;
        if (diff > (AW+1)'(pi_f)) diff_w = diff - (AW+1)'(2 * pi_f);
        if (diff_w < -(AW+1)'(pi_f)) diff_w = diff_w + (AW+1)'(2 * pi_f);
    end
    logic signed [AW:0] adiff;
    assign adiff = diff_w[AW] ? -diff_w : diff_w;
    assign stat.need_mirror = x_reg[15] && (adiff > (AW+1)'(half_pi_f));
    assign stat.sqrt_done = sq_done;
    assign stat.cordic_done = c_done;

    // Angular limit as a signed quantity so that negative commands clamp correctly.
    logic signed [AW+17:0] lim_ang;
    assign lim_ang = (AW+18)'($signed({1'b0, cfg.max_ang}));

    // Decision logic over the registered quantities.
    logic [1:0] ph;
    logic signed [AW-1:0] abear, ayaw, turn_ang;
    logic signed [AW+17:0] prod_rot, prod_tran;
    logic signed [AW+17:0] rnd_rot, rnd_tran;
    logic signed [15:0] lin_n, ang_n;
    logic valid_n;
    always_comb begin
        ph = restart_reg ? PH_TURN_POS : phase_reg;
        abear = bear_reg[AW-1] ? -bear_reg : bear_reg;
        ayaw = yaw_reg[AW-1] ? -yaw_reg : yaw_reg;
        turn_ang = (ph == PH_TURN_POS) ? bear_reg : yaw_reg;
        prod_rot = $signed({2'b0, cfg.rot_gain}) * (AW+18)'(turn_ang);
        prod_tran = $signed({2'b0, cfg.tran_gain}) * (AW+18)'($signed({1'b0, d_reg}));
        rnd_rot = (prod_rot + ((AW+18)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        rnd_tran = (prod_tran + ((AW+18)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        lin_n = '0;
        ang_n = '0;
        valid_n = 1'b0;
        phase_next = ph;
        if (rnd_rot > lim_ang) begin
            ang_n = 16'(cfg.max_ang);
        end else if (rnd_rot < -lim_ang) begin
            ang_n = -16'(cfg.max_ang);
        end else begin
            ang_n = 16'(rnd_rot);
        end
        unique case (ph)
            PH_TURN_POS: begin
                if (d_reg < 16'(cfg.pos_tol)) begin
                    phase_next = PH_TURN_ORNT;
                    ang_n = '0;
                end else if (abear < AW'(cfg.bear_tol)) begin
                    phase_next = PH_MOVE;
                    ang_n = '0;
                end else begin
                    valid_n = 1'b1;
                end
            end
            PH_MOVE: begin
                ang_n = '0;
                if (d_reg < 16'(cfg.pos_tol)) begin
                    phase_next = PH_TURN_ORNT;
                end else begin
                    if (rnd_tran > (AW+18)'(cfg.max_lin)) begin
                        lin_n = 16'(cfg.max_lin);
                    end else begin
                        lin_n = 16'(rnd_tran);
                    end
                    if (!(x_reg > 0)) lin_n = -lin_n;
                    valid_n = 1'b1;
                end
            end
            PH_TURN_ORNT: begin
                if (ayaw < AW'(cfg.head_tol)) begin
                    phase_next = PH_DONE;
                    ang_n = '0;
                end else begin
                    valid_n = 1'b1;
                end
            end
            default: ang_n = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TURN_POS;
        end else if (cmd.decide) begin
            phase_reg <= phase_next;
        end
        if (cmd.load) begin
            restart_reg <= s_restart;
            x_reg <= s_goal_rel_x;
            y_reg <= s_goal_rel_y;
            yaw_num_reg <= 36'(pxy) * 2 + 36'(pwz) * 2;
            yaw_den_reg <= 36'(pxx) + 36'(pww) - 36'(pzz) - 36'(pyy);
        end
        if (cmd.cordic_start) sel_reg <= cmd.cordic_sel;
        if (sq_done) d_reg <= sq_root;
        if (c_done) begin
            if (sel_reg == 2'd0) begin
                yaw_reg <= angle_f;
            end else begin
                bear_reg <= (sel_reg == 2'd1 && !($signed({1'b0, d_reg}) > 17'(NEAR_D)))
                            ? '0 : angle_f;
            end
        end
        if (cmd.decide) begin
            m_linear_cmd <= lin_n;
            m_angular_cmd <= ang_n;
            m_cmd_valid <= valid_n;
        end
    end

    // The phase register is the reported phase; it is defined from reset on.
    assign m_phase_now = phase_reg;
    assign m_aligned = (phase_reg == PH_DONE);
endmodule

// ===== design/gac_ctrl.sv =====
// Controller: sequences capture, root, CORDIC runs and the decision.
module gac_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic               restart_in,
    input  logic [1:0]         phase_in,
    input  gac_pkg::gac_stat_t stat,
    output gac_pkg::gac_cmd_t  cmd
);
    import gac_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQRT = 7'b0000010,
        S_YAW  = 7'b0000100,
        S_BEAR = 7'b0001000,
        S_MIRR = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } st_t;

    st_t state_reg, state_next;
    logic restart_reg;
    logic cwait_reg, cwait_next;

    always_comb begin
        state_next = state_reg;
        cwait_next = cwait_reg;
        cmd = '0;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_SQRT;
                    cwait_next = 1'b0;
                end
            end
            S_SQRT: begin
                cmd.sqrt_start = !cwait_reg;
                cwait_next = 1'b1;
                if (stat.sqrt_done) begin
                    state_next = S_YAW;
                    cwait_next = 1'b0;
                end
            end
            S_YAW: begin
                cmd.cordic_sel = 2'd0;
                cmd.cordic_start = !cwait_reg;
                cwait_next = 1'b1;
                if (stat.cordic_done) begin
                    state_next = S_BEAR;
                    cwait_next = 1'b0;
                end
            end
            S_BEAR: begin
                cmd.cordic_sel = 2'd1;
                cmd.cordic_start = !cwait_reg;
                cwait_next = 1'b1;
                if (stat.cordic_done) begin
                    cwait_next = 1'b0;
                    state_next = S_MIRR;
                end
            end
            S_MIRR: begin
                // Mirrored bearing only matters in turn-to-position.
                cmd.cordic_sel = 2'd2;
                if (!cwait_reg) begin
                    if ((restart_reg || phase_in == PH_TURN_POS) && stat.need_mirror) begin
                        cmd.cordic_start = 1'b1;
                        cwait_next = 1'b1;
                    end else begin
                        state_next = S_DEC;
                    end
                end else if (stat.cordic_done) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cwait_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cwait_reg <= cwait_next;
        end
        if (cmd.load) restart_reg <= restart_in;
    end
endmodule

// ===== design/goal_alignment_controller_unit.sv =====
// Goal alignment controller. One transaction on the s_ channel is one control
// tick and yields exactly one transaction on the m_ channel. A tick runs the
// bit-serial root (16 steps) and then the shared one-step-a-cycle CORDIC for
// the yaw, the bearing and, when it is needed, the mirrored bearing, each run
// normalizing its vector first. Configuration writes are taken at any time and
// should be made only while the block is idle.
module goal_alignment_controller_unit #(
    parameter int FRAC_BITS = 12,
    parameter int CORDIC_ITERS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    input  logic signed [15:0] s_goal_rel_x,
    input  logic signed [15:0] s_goal_rel_y,
    input  logic signed [15:0] s_goal_quat_w,
    input  logic signed [15:0] s_goal_quat_x,
    input  logic signed [15:0] s_goal_quat_y,
    input  logic signed [15:0] s_goal_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_linear_cmd,
    output logic signed [15:0] m_angular_cmd,
    output logic               m_cmd_valid,
    output logic [1:0]         m_phase_now,
    output logic               m_aligned,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import gac_pkg::*;

    gac_cfg_t cfg_reg;
    gac_cmd_t cmd;
    gac_stat_t stat;
    logic [1:0] phase_now;

    assign cfg_ready = 1'b1;

    // Register file write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_lin   <= 15'd2048;
            cfg_reg.max_ang   <= 15'd4096;
            cfg_reg.bear_tol  <= 14'd179;
            cfg_reg.pos_tol   <= 15'd410;
            cfg_reg.head_tol  <= 14'd71;
            cfg_reg.rot_gain  <= 16'd4096;
            cfg_reg.tran_gain <= 16'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_LIN:   cfg_reg.max_lin   <= cfg_data[14:0];
                REG_MAX_ANG:   cfg_reg.max_ang   <= cfg_data[14:0];
                REG_BEAR_TOL:  cfg_reg.bear_tol  <= cfg_data[13:0];
                REG_POS_TOL:   cfg_reg.pos_tol   <= cfg_data[14:0];
                REG_HEAD_TOL:  cfg_reg.head_tol  <= cfg_data[13:0];
                REG_ROT_GAIN:  cfg_reg.rot_gain  <= cfg_data;
                REG_TRAN_GAIN: cfg_reg.tran_gain <= cfg_data;
                default: ;
            endcase
        end
    end

    gac_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .restart_in(s_restart),
        .phase_in(phase_now), .stat(stat), .cmd(cmd)
    );

    gac_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .cfg(cfg_reg),
        .s_restart(s_restart), .s_goal_rel_x(s_goal_rel_x),
        .s_goal_rel_y(s_goal_rel_y), .s_goal_quat_w(s_goal_quat_w),
        .s_goal_quat_x(s_goal_quat_x), .s_goal_quat_y(s_goal_quat_y),
        .s_goal_quat_z(s_goal_quat_z), .m_linear_cmd(m_linear_cmd),
        .m_angular_cmd(m_angular_cmd), .m_cmd_valid(m_cmd_valid),
        .m_phase_now(phase_now), .m_aligned(m_aligned)
    );

    assign m_phase_now = phase_now;
endmodule

// ===== design/gac_checker.sv =====
// Port-level checks for the goal alignment controller.
module gac_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [15:0] m_linear_cmd,
    input logic signed [15:0] m_angular_cmd,
    input logic              m_cmd_valid,
    input logic [1:0]        m_phase_now,
    input logic              m_aligned
);
    import gac_pkg::*;

    // A result that is offered stays until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase_now))
        else $error("result changed while stalled");

    // One tick at a time: no input taken while a result waits.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted with result pending");

    // Aligned matches the done phase.
    a_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_aligned == (m_phase_now == PH_DONE)))
        else $error("aligned flag disagrees with phase");

    // A result without a command carries zero on both command fields.
    a_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_cmd_valid |-> m_linear_cmd == 0 && m_angular_cmd == 0)
        else $error("command output without command valid");
endmodule

bind goal_alignment_controller_unit gac_checker u_gac_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_linear_cmd(m_linear_cmd),
    .m_angular_cmd(m_angular_cmd), .m_cmd_valid(m_cmd_valid),
    .m_phase_now(m_phase_now), .m_aligned(m_aligned)
);
